### hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("assertion failed");

// Same, on the usual clk / arst_n of the enclosing scope.
`define ASSERT_CLK(label, prop) `ASSERT_AT(label, clk, arst_n, prop)

`endif

### hdl/spq_pkg.sv
// Shared types, codes and stream field offsets for the priority queue scheduler.
package spq_pkg;

	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_RECORD_BITS = 32;
	localparam int NUM_CLASSES     = 3;

	localparam int REC_FIELD_W = 32;
	localparam int WAIT_W      = 8;

	// Input stream layout
	localparam int IN_CLS_LSB  = 0;
	localparam int IN_REC_LSB  = 2;
	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;

	// Output stream layout
	localparam int OUT_SP_LSB  = 0;
	localparam int OUT_SR_LSB  = 2;
	localparam int OUT_TW_LSB  = 34;
	localparam int OUT_HP_LSB  = 42;
	localparam int OUT_HR_LSB  = 44;
	localparam int OUT_SF_BIT  = 76;
	localparam int OUT_TDATA_W = 80;
	localparam int OUT_TUSER_W = 1;

	typedef enum logic [1:0] {
		KIND_ENQ   = 2'd0,
		KIND_SERVE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CLS_URGENT = 2'd0,
		CLS_MIDDLE = 2'd1,
		CLS_LOW    = 2'd2,
		CLS_NONE   = 2'd3
	} cls_t;

	// Per-queue control from the scheduler
	typedef struct packed {
		logic push;
		logic pop;
	} qctl_t;

endpackage

### hdl/spq_queue.sv
// One FIFO queue: record memory, pointers, count and a cached head / next-head pair.
module spq_queue #(
	parameter int DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
	parameter int RB    = spq_pkg::DEF_RECORD_BITS,
	localparam int CW   = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::qctl_t    ctl,
	input  logic [RB-1:0]     wr_data,
	output logic [CW-1:0]     occ,
	output logic [CW-1:0]     occ_nxt,
	output logic [RB-1:0]     head,
	output logic [RB-1:0]     head_nxt
);
	import spq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [RB-1:0] mem [DEPTH];
	logic [AW-1:0] head_ptr_q, tail_ptr_q, head_ptr_d, rd_addr;
	logic [CW-1:0] occ_q;
	logic [RB-1:0] head_val_q, nxt_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		head_ptr_d = ctl.pop ? ptr_inc(head_ptr_q) : head_ptr_q;
		// entry behind the head as it stands after this cycle
		rd_addr    = ptr_inc(head_ptr_d);

		occ_nxt = occ_q;
		if (ctl.push) begin
			occ_nxt = occ_q + CW'(1);
		end else if (ctl.pop) begin
			occ_nxt = occ_q - CW'(1);
		end

		head_nxt = head_val_q;
		if (ctl.push && occ_q == '0) begin
			head_nxt = wr_data;
		end else if (ctl.pop) begin
			head_nxt = nxt_q;
		end
	end

	assign occ  = occ_q;
	assign head = head_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_ptr_q <= '0;
			tail_ptr_q <= '0;
			occ_q      <= '0;
		end else begin
			head_ptr_q <= head_ptr_d;
			occ_q      <= occ_nxt;
			if (ctl.push) begin
				tail_ptr_q <= ptr_inc(tail_ptr_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		head_val_q <= head_nxt;
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_ptr_q] <= wr_data;
		end
	end

	// registered read of the next-to-head entry, write data forwarded
	always_ff @(posedge clk) begin
		if (ctl.push && tail_ptr_q == rd_addr) begin
			nxt_q <= wr_data;
		end else begin
			nxt_q <= mem[rd_addr];
		end
	end

endmodule

### hdl/strict_priority_three_queue_scheduler.sv
// Strict-priority scheduler: three class queues, one server, one item per cycle unless
//   the output stalls. An accepted item is held in the input register until the result
//   register is empty or being drained, then its result is registered onto m_tvalid.
// Throughput: one item per cycle while m_tready is high; the queue count/pointer update
//   and head select between the input register and the result register set that figure.
// Reset (arst_n low, async): queues empty, server free, both stream stages empty.
module strict_priority_three_queue_scheduler #(
	parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH,
	parameter int RECORD_BITS = spq_pkg::DEF_RECORD_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [1:0] priority_req, [33:2] record, [39:34] zero
	input  logic [spq_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [1:0] kind
	input  logic [spq_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] served_priority, [33:2] served_record, [41:34] total_waiting,
	// [43:42] head_priority, [75:44] head_record, [76] server_free, [79:77] zero
	output logic [spq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	// [0] ok
	output logic [spq_pkg::OUT_TUSER_W-1:0]   m_tuser
);
	import spq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = WAIT_W + CW + 2;

	// input stage
	logic                   valid_s1;
	kind_t                  kind_s1;
	cls_t                   cls_s1;
	logic [RECORD_BITS-1:0] rec_s1;
	logic [63:0]            rec_in_wide;

	// queue side
	qctl_t                  qctl     [NUM_CLASSES];
	logic [CW-1:0]          occ      [NUM_CLASSES];
	logic [CW-1:0]          occ_nxt  [NUM_CLASSES];
	logic [RECORD_BITS-1:0] head     [NUM_CLASSES];
	logic [RECORD_BITS-1:0] head_nxt [NUM_CLASSES];

	logic server_q, server_d;
	logic commit, s_acc;

	// step results
	logic                   ok_d;
	cls_t                   top_old, top_new, served_cls_d;
	logic [RECORD_BITS-1:0] served_rec_d, head_rec_d;
	logic [SW-1:0]          total_sum;
	logic [63:0]            served_wide, head_wide;

	// result register
	logic                   m_valid_q;
	logic                   ok_q;
	cls_t                   sp_q, hp_q;
	logic [REC_FIELD_W-1:0] sr_q, hr_q;
	logic [WAIT_W-1:0]      tw_q;
	logic                   sf_q;

	assign s_acc    = s_tvalid && s_tready;
	assign commit   = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || commit;

	assign rec_in_wide = {32'b0, s_tdata[IN_REC_LSB +: REC_FIELD_W]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1 <= kind_t'(s_tuser[1:0]);
			cls_s1  <= cls_t'(s_tdata[IN_CLS_LSB +: 2]);
			rec_s1  <= rec_in_wide[RECORD_BITS-1:0];
		end
	end

	for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_queue
		spq_queue #(
			.DEPTH (QUEUE_DEPTH),
			.RB    (RECORD_BITS)
		) u_queue (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (qctl[g]),
			.wr_data  (rec_s1),
			.occ      (occ[g]),
			.occ_nxt  (occ_nxt[g]),
			.head     (head[g]),
			.head_nxt (head_nxt[g])
		);
	end

	// Step logic. Queue pushes/pops and the server flag only move on commit;
	// the status fields are then taken from the post-step queue view.
	always_comb begin
		top_old = CLS_NONE;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (occ[c] != '0) begin
				top_old = cls_t'(2'(c));
			end
		end

		for (int c = 0; c < NUM_CLASSES; c++) begin
			qctl[c] = '0;
		end
		ok_d         = 1'b0;
		served_cls_d = CLS_NONE;
		served_rec_d = '0;
		server_d     = server_q;

		case (kind_s1)
			KIND_ENQ: begin
				for (int c = 0; c < NUM_CLASSES; c++) begin
					if (cls_s1 == cls_t'(2'(c)) && occ[c] != CW'(QUEUE_DEPTH)) begin
						ok_d         = 1'b1;
						qctl[c].push = commit;
					end
				end
			end
			KIND_SERVE: begin
				if (server_q && top_old != CLS_NONE) begin
					ok_d         = 1'b1;
					served_cls_d = top_old;
					server_d     = 1'b0;
					for (int c = 0; c < NUM_CLASSES; c++) begin
						if (top_old == cls_t'(2'(c))) begin
							served_rec_d = head[c];
							qctl[c].pop  = commit;
						end
					end
				end
			end
			KIND_END: begin
				if (!server_q) begin
					ok_d     = 1'b1;
					server_d = 1'b1;
				end
			end
			default: begin
			end
		endcase

		top_new    = CLS_NONE;
		head_rec_d = '0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (occ_nxt[c] != '0) begin
				top_new    = cls_t'(2'(c));
				head_rec_d = head_nxt[c];
			end
		end

		total_sum = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			total_sum = total_sum + SW'(occ_nxt[c]);
		end

		served_wide = 64'(served_rec_d);
		head_wide   = 64'(head_rec_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_q  <= 1'b1;
			m_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				server_q <= server_d;
			end
			if (commit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			ok_q <= ok_d;
			sp_q <= served_cls_d;
			sr_q <= served_wide[REC_FIELD_W-1:0];
			tw_q <= total_sum[WAIT_W-1:0];
			hp_q <= top_new;
			hr_q <= head_wide[REC_FIELD_W-1:0];
			sf_q <= server_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = ok_q;
	assign m_tdata  = {3'b000, sf_q, hr_q, hp_q, tw_q, sr_q, sp_q};

endmodule

### hdl/spq_checker.sv
// Port-level checker for the priority queue scheduler, bound to the top level.
`include "assert_macros.svh"

module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [spq_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input logic [spq_pkg::OUT_TUSER_W-1:0]   m_tuser
);
	import spq_pkg::*;

	logic                   stall;
	logic                   ok_f;
	logic                   sf_f;
	logic [1:0]             sp_f;
	logic [1:0]             hp_f;
	logic [REC_FIELD_W-1:0] sr_f;
	logic [REC_FIELD_W-1:0] hr_f;
	logic [WAIT_W-1:0]      tw_f;

	assign stall = m_tvalid && !m_tready;
	assign ok_f  = m_tuser[0];
	assign sf_f  = m_tdata[OUT_SF_BIT];
	assign sp_f  = m_tdata[OUT_SP_LSB +: 2];
	assign hp_f  = m_tdata[OUT_HP_LSB +: 2];
	assign sr_f  = m_tdata[OUT_SR_LSB +: REC_FIELD_W];
	assign hr_f  = m_tdata[OUT_HR_LSB +: REC_FIELD_W];
	assign tw_f  = m_tdata[OUT_TW_LSB +: WAIT_W];

	// a stalled result keeps its contents
	`ASSERT_CLK(a_out_hold, stall |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a successful serve always leaves the server busy
	`ASSERT_CLK(a_serve_busy, m_tvalid && ok_f && sp_f != CLS_NONE |-> !sf_f)

	// no class served means no record reported
	`ASSERT_CLK(a_no_serve_zero, m_tvalid && sp_f == CLS_NONE |-> sr_f == '0)

	// all queues empty: nothing waiting and no head record
	`ASSERT_CLK(a_empty_head, m_tvalid && hp_f == CLS_NONE |-> tw_f == '0 && hr_f == '0)

endmodule

bind strict_priority_three_queue_scheduler spq_checker u_spq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
